// ===== sv/earliest_free_worker_scheduler_top_macros.svh =====
// ----------------------------------------------------------------------------
// earliest free worker scheduler assertion macros
// clocked property checks on clk; EFWS_ASSERT is disabled while rst_n is low, EFWS_ASSERT_ALWAYS is not
// ----------------------------------------------------------------------------
`ifndef EARLIEST_FREE_WORKER_SCHEDULER_TOP_MACROS_SVH
`define EARLIEST_FREE_WORKER_SCHEDULER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// property checked at every rising edge outside reset
`define EFWS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// property checked at every rising edge, reset included
`define EFWS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define EFWS_ASSERT(lbl, prop, msg)
`define EFWS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== sv/efws_pkg.sv =====
// ----------------------------------------------------------------------------
// efws_pkg
// shared types and constants of the earliest free worker scheduler
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package efws_pkg;

  localparam int DUR_W  = 32;
  localparam int TIME_W = 48;
  localparam int IDX_W  = 4;
  localparam int CFG_W  = 5;
  localparam int OUT_W  = 56;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic issue;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_issue;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== sv/efws_ctrl.sv =====
// ----------------------------------------------------------------------------
// efws_ctrl
// sequencer: accept a job, scan the workers, drain the read, commit the result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module efws_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  input  wire efws_pkg::sts_t  sts,
  output efws_pkg::cmd_t       cmd
);

  efws_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= efws_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      efws_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = efws_pkg::ST_SCAN;
      end
      efws_pkg::ST_SCAN: begin
        if (sts.last_issue) state_nxt = efws_pkg::ST_DRAIN;
      end
      efws_pkg::ST_DRAIN: begin
        state_nxt = efws_pkg::ST_UPDATE;
      end
      efws_pkg::ST_UPDATE: begin
        if (sts.out_free) state_nxt = efws_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = efws_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    cmd        = '0;
    case (state_r)
      efws_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      efws_pkg::ST_SCAN: begin
        cmd.issue = 1'b1;
      end
      efws_pkg::ST_DRAIN: begin
        cmd = '0;
      end
      efws_pkg::ST_UPDATE: begin
        cmd.commit = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/efws_dp.sv =====
// ----------------------------------------------------------------------------
// efws_dp
// free time memory, running minimum over a worker scan, saturating update
// and the result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "earliest_free_worker_scheduler_top_macros.svh"

module efws_dp #(
  parameter int MAX_WORKERS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire efws_pkg::cmd_t                cmd,
  output efws_pkg::sts_t                     sts,
  input  wire logic [efws_pkg::CFG_W-1:0]    active_workers,
  input  wire logic [efws_pkg::DUR_W-1:0]    job_duration,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [efws_pkg::OUT_W-1:0]         out_tdata
);

  localparam int IW   = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int CNTW = $clog2(MAX_WORKERS + 1);
  localparam int EW   = (CNTW > efws_pkg::CFG_W) ? CNTW : efws_pkg::CFG_W;
  localparam int TW   = efws_pkg::TIME_W;
  localparam int PADW = efws_pkg::OUT_W - efws_pkg::IDX_W - TW - 1;

  logic [TW-1:0]               mem [MAX_WORKERS];
  logic [MAX_WORKERS-1:0]      vld_r;

  logic [efws_pkg::DUR_W-1:0]  dur_r;
  logic [IW-1:0]               last_r;
  logic [IW-1:0]               addr_r;
  logic                        rd_vld_r;
  logic [IW-1:0]               rd_idx_r;
  logic [TW-1:0]               rd_data_r;
  logic                        rd_fv_r;
  logic [IW-1:0]               best_idx_r;
  logic [TW-1:0]               best_time_r;

  logic                        out_valid_r;
  logic [efws_pkg::IDX_W-1:0]  out_idx_r;
  logic [TW-1:0]               out_start_r;
  logic                        out_ovf_r;

  logic [EW-1:0]               n_ext;
  logic [EW-1:0]               n_eff;
  logic [IW-1:0]               last_nxt;
  logic [TW-1:0]               cur_time;
  logic [TW:0]                 sum;
  logic [TW-1:0]               new_time;
  logic                        ovf;

  // effective worker count clamped to 1..MAX_WORKERS
  always_comb begin
    n_ext = EW'(active_workers);
    if (n_ext == '0) begin
      n_eff = EW'(1);
    end else if (n_ext > EW'(MAX_WORKERS)) begin
      n_eff = EW'(MAX_WORKERS);
    end else begin
      n_eff = n_ext;
    end
    last_nxt = IW'(n_eff - EW'(1));
  end

  // a never written entry reads as zero
  assign cur_time = rd_fv_r ? rd_data_r : '0;

  assign sum      = {1'b0, best_time_r} + {{(TW + 1 - efws_pkg::DUR_W){1'b0}}, dur_r};
  assign ovf      = sum[TW];
  assign new_time = ovf ? efws_pkg::TIME_MAX : sum[TW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_data_r <= mem[addr_r];
      rd_fv_r   <= vld_r[addr_r];
    end
    if (cmd.commit) begin
      mem[best_idx_r] <= new_time;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.commit) begin
      vld_r[best_idx_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dur_r  <= job_duration;
      last_r <= last_nxt;
      addr_r <= '0;
    end else if (cmd.issue) begin
      addr_r <= addr_r + IW'(1);
    end
    if (cmd.issue) begin
      rd_idx_r <= addr_r;
    end
    // strict less keeps the lowest index on a tie
    if (rd_vld_r && ((rd_idx_r == '0) || (cur_time < best_time_r))) begin
      best_idx_r  <= rd_idx_r;
      best_time_r <= cur_time;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_idx_r   <= efws_pkg::IDX_W'(best_idx_r);
      out_start_r <= best_time_r;
      out_ovf_r   <= ovf;
    end
  end

  assign sts.last_issue = cmd.issue && (addr_r == last_r);
  assign sts.out_free   = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PADW{1'b0}}, out_ovf_r, out_start_r, out_idx_r};

  `EFWS_ASSERT(a_commit_slot, cmd.commit |-> sts.out_free, "commit with result slot busy")
  `EFWS_ASSERT(a_commit_valid, cmd.commit |=> (out_valid_r && vld_r[$past(best_idx_r)]),
               "commit did not mark result and entry")
  `EFWS_ASSERT(a_read_range, rd_vld_r |-> (rd_idx_r <= last_r), "scan read beyond active set")
  `EFWS_ASSERT(a_no_overlap, cmd.load |-> (!cmd.issue && !cmd.commit && !rd_vld_r),
               "job loaded during a scan")

endmodule

`default_nettype wire

// ===== sv/earliest_free_worker_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// earliest_free_worker_scheduler_top
// assigns each job to the active worker that frees up first
//
// channel  dir  handshake          payload
// in_      in   tvalid/tready      tdata[31:0] job_duration
// out_     out  tvalid/tready      tdata[3:0] worker_index, [51:4] start_time,
//                                  [52] time_overflow, [55:53] zero
// cfg_     in   psel/penable       register 0 at 0x0: active_workers[4:0]
//
// between accept and the next accept a job makes one free time memory read
// per active worker, waits in a drain step for the last read to land, then
// takes an update step for the update and result
// rst_n clears all free times to zero (per entry valid bits), count to 1
// a result waiting on out_tready holds the update cycle; no job is taken then
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module earliest_free_worker_scheduler_top #(
  parameter int MAX_WORKERS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // job_duration[31:0]
  input  wire logic [31:0] in_tdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // worker_index[3:0], start_time[51:4], time_overflow[52], zero fill[55:53]
  output logic [55:0]      out_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic [efws_pkg::CFG_W-1:0] active_r;
  logic                       cfg_wr;
  logic                       cfg_sel0;
  efws_pkg::cmd_t             cmd;
  efws_pkg::sts_t             sts;

  assign cfg_pready = 1'b1;
  assign cfg_sel0   = (cfg_paddr[2] == 1'b0);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= efws_pkg::CFG_W'(1);
    end else if (cfg_wr && cfg_sel0) begin
      active_r <= cfg_pwdata[efws_pkg::CFG_W-1:0];
    end
  end

  assign cfg_prdata = cfg_sel0 ? {{(32 - efws_pkg::CFG_W){1'b0}}, active_r} : 32'd0;

  efws_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  efws_dp #(
    .MAX_WORKERS (MAX_WORKERS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .active_workers (active_r),
    .job_duration   (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata)
  );

endmodule

`default_nettype wire
